### rtl/mfs_pkg.sv
// Shared constants for the multilevel feedback scheduler.
// Holds request and status codes and the parameter defaults.
// Depends on nothing.
package mfs_pkg;

  localparam int NUM_PROCS_DEF  = 64;
  localparam int NUM_LEVELS_DEF = 8;

  localparam int REQ_W    = 2;
  localparam int PID_W    = 6;
  localparam int CFG_W    = 3;
  localparam int STATUS_W = 2;

  localparam logic [REQ_W-1:0] REQ_SCHED  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REBAL  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ENQ    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_PICKED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;

  localparam logic [CFG_W-1:0] DEFAULT_LEVEL_RST = 3'd7;

endpackage

### rtl/mfs_ram.sv
// Generic single write, single read RAM with a registered read port.
// Depends on nothing.
module mfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/multilevel_feedback_scheduler.sv
// Multilevel feedback queue scheduler, top level.
// Depends on mfs_pkg and mfs_ram.
//
// Usage:
//   Input channel (in_*): one request per transfer: schedule, rebalance or
//   enqueue. Result channel (out_*): exactly one result per request, holding
//   a status and, for a pick, the picked process id.
//   Config channel (cfg_*): writes default_level; always ready. Write it only
//   while the block is idle.
// Sequencing: a schedule runs the level read of the current process,
//   requeue, pick and link read on pop; a rebalance sweeps the level
//   memory, which has one write port, one entry a cycle. One request is in
//   work at a time; in_ready is high only while no request is in work.
// Reset: rst_n is synchronous, active low. After reset the block sweeps the
//   level memory to zero with in_ready low; config writes are taken
//   meanwhile. All ready queues start empty.
// Stall: a finished result waits in the output register; the next request
//   is taken meanwhile and its result waits until the register frees.
module multilevel_feedback_scheduler #(
  parameter int NUM_PROCS  = mfs_pkg::NUM_PROCS_DEF,
  parameter int NUM_LEVELS = mfs_pkg::NUM_LEVELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mfs_pkg::REQ_W-1:0]    in_req_type,
  input  logic [mfs_pkg::PID_W-1:0]    in_proc_id,
  input  logic                         in_has_current,
  input  logic                         in_current_runnable,
  input  logic                         in_quantum_left,
  input  logic                         in_is_user,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mfs_pkg::STATUS_W-1:0] out_status,
  output logic [mfs_pkg::PID_W-1:0]    out_picked_id,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mfs_pkg::CFG_W-1:0]    cfg_default_level
);

  localparam int IDW = $clog2(NUM_PROCS);
  localparam int LW  = $clog2(NUM_LEVELS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SWEEP, S_ENQ, S_REQ, S_PICK, S_POP, S_DONE
  } state_t;

  state_t                         state_r, state_nxt;
  logic [mfs_pkg::CFG_W-1:0]      default_level_r;
  logic [IDW-1:0]                 idx_r, idx_nxt;
  logic                           quantum_r, quantum_nxt;
  logic                           user_r, user_nxt;
  logic [IDW-1:0]                 cnt_r, cnt_nxt;
  logic [LW-1:0]                  sweep_val_r, sweep_val_nxt;
  logic [LW-1:0]                  pick_lvl_r, pick_lvl_nxt;
  logic [mfs_pkg::STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [IDW-1:0]                 res_id_r, res_id_nxt;
  logic                           out_valid_r;
  logic [mfs_pkg::STATUS_W-1:0]   out_status_r;
  logic [mfs_pkg::PID_W-1:0]      out_id_r;

  // Queue descriptors: head and tail per level, one read address a cycle.
  logic [IDW-1:0]        head_r [NUM_LEVELS];
  logic [IDW-1:0]        tail_r [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] nonempty_r;

  // Derived values
  logic [31:0]    dl_ext, id_ext, res_ext;
  logic [LW-1:0]  dl_c;
  logic [IDW-1:0] in_idx;
  logic           in_range;
  logic [LW-1:0]  cur_lv, new_lv, ht_lv, pick_c;
  logic           pick_found;
  logic [IDW-1:0] ht_head, ht_tail;
  logic           ht_ne;
  logic           out_free;

  // Memories
  logic           lvl_we;
  logic [IDW-1:0] lvl_waddr, lvl_raddr;
  logic [LW-1:0]  lvl_wdata, lvl_rdata;
  logic           lnk_we;
  logic [IDW-1:0] lnk_waddr, lnk_wdata, lnk_raddr, lnk_rdata;

  assign dl_ext   = 32'(default_level_r);
  assign dl_c     = (dl_ext >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1) : dl_ext[LW-1:0];
  assign id_ext   = 32'(in_proc_id);
  assign in_idx   = id_ext[IDW-1:0];
  assign in_range = id_ext < NUM_PROCS;

  // Demote a user process that used up its quantum, unless at the bottom.
  assign cur_lv = lvl_rdata;
  assign new_lv = (!quantum_r && user_r && cur_lv != '0) ? cur_lv - 1'b1 : cur_lv;

  // Highest non-empty level.
  always_comb begin
    pick_c     = '0;
    pick_found = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (nonempty_r[i]) begin
        pick_c     = LW'(i);
        pick_found = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (state_r)
      S_REQ:   ht_lv = new_lv;
      S_ENQ:   ht_lv = dl_c;
      S_PICK:  ht_lv = pick_c;
      default: ht_lv = pick_lvl_r;
    endcase
  end

  assign ht_head = head_r[ht_lv];
  assign ht_tail = tail_r[ht_lv];
  assign ht_ne   = nonempty_r[ht_lv];

  assign out_free = !out_valid_r || out_ready;

  // Level memory port control: sweep, enqueue and a requeue after a used-up quantum write it.
  always_comb begin
    lvl_we    = 1'b0;
    lvl_waddr = idx_r;
    lvl_wdata = dl_c;
    unique case (state_r)
      S_CLEAR, S_SWEEP: begin
        lvl_we    = 1'b1;
        lvl_waddr = cnt_r;
        lvl_wdata = sweep_val_r;
      end
      S_ENQ: lvl_we = 1'b1;
      S_REQ: begin
        lvl_we    = !quantum_r;
        lvl_wdata = new_lv;
      end
      default: lvl_we = 1'b0;
    endcase
  end
  assign lvl_raddr = in_idx;

  // Link memory: tail push links old tail to the process, head push links
  // the process to the old head.
  always_comb begin
    lnk_we    = 1'b0;
    lnk_waddr = ht_tail;
    lnk_wdata = idx_r;
    unique case (state_r)
      S_ENQ: lnk_we = ht_ne;
      S_REQ: begin
        lnk_we = ht_ne;
        if (quantum_r) begin
          lnk_waddr = idx_r;
          lnk_wdata = ht_head;
        end
      end
      default: lnk_we = 1'b0;
    endcase
  end
  assign lnk_raddr = ht_head;

  mfs_ram #(.WIDTH(LW), .DEPTH(NUM_PROCS)) u_level_ram (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (lvl_waddr),
    .wdata (lvl_wdata),
    .raddr (lvl_raddr),
    .rdata (lvl_rdata)
  );

  mfs_ram #(.WIDTH(IDW), .DEPTH(NUM_PROCS)) u_link_ram (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .raddr (lnk_raddr),
    .rdata (lnk_rdata)
  );

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    quantum_nxt    = quantum_r;
    user_nxt       = user_r;
    cnt_nxt        = cnt_r;
    sweep_val_nxt  = sweep_val_r;
    pick_lvl_nxt   = pick_lvl_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    unique case (state_r)
      S_CLEAR, S_SWEEP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IDW'(NUM_PROCS - 1)) begin
          state_nxt = (state_r == S_CLEAR) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt        = in_idx;
          quantum_nxt    = in_quantum_left;
          user_nxt       = in_is_user;
          res_status_nxt = mfs_pkg::ST_DONE;
          res_id_nxt     = '0;
          priority case (in_req_type)
            mfs_pkg::REQ_SCHED: begin
              // Level read of the current process issues this cycle.
              state_nxt = (in_has_current && in_current_runnable && in_range) ?
                          S_REQ : S_PICK;
            end
            mfs_pkg::REQ_REBAL: begin
              sweep_val_nxt = dl_c;
              cnt_nxt       = '0;
              state_nxt     = S_SWEEP;
            end
            mfs_pkg::REQ_ENQ: state_nxt = in_range ? S_ENQ : S_DONE;
            default:          state_nxt = S_DONE;
          endcase
        end
      end
      S_ENQ:  state_nxt = S_DONE;
      S_REQ:  state_nxt = S_PICK;
      S_PICK: begin
        pick_lvl_nxt = pick_c;
        if (!pick_found) begin
          res_status_nxt = mfs_pkg::ST_EMPTY;
          state_nxt      = S_DONE;
        end else begin
          res_status_nxt = mfs_pkg::ST_PICKED;
          res_id_nxt     = ht_head;
          state_nxt      = (ht_head == ht_tail) ? S_DONE : S_POP;
        end
      end
      S_POP:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      cnt_r           <= '0;
      sweep_val_r     <= '0;
      default_level_r <= mfs_pkg::DEFAULT_LEVEL_RST;
      nonempty_r      <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sweep_val_r <= sweep_val_nxt;
      if (cfg_valid) begin
        default_level_r <= cfg_default_level;
      end
      // Queue descriptor updates
      unique case (state_r)
        S_ENQ: begin
          if (!ht_ne) begin
            head_r[ht_lv]     <= idx_r;
            nonempty_r[ht_lv] <= 1'b1;
          end
          tail_r[ht_lv] <= idx_r;
        end
        S_REQ: begin
          if (!ht_ne) begin
            nonempty_r[ht_lv] <= 1'b1;
            head_r[ht_lv]     <= idx_r;
            tail_r[ht_lv]     <= idx_r;
          end else if (quantum_r) begin
            head_r[ht_lv] <= idx_r;
          end else begin
            tail_r[ht_lv] <= idx_r;
          end
        end
        S_PICK: begin
          if (pick_found && ht_head == ht_tail) begin
            nonempty_r[ht_lv] <= 1'b0;
          end
        end
        S_POP: head_r[ht_lv] <= lnk_rdata;
        default: ;
      endcase
      // Output register: load a finished result, drop it once taken.
      if (state_r == S_DONE && out_free) begin
        out_valid_r  <= 1'b1;
        out_status_r <= res_status_r;
        out_id_r     <= res_ext[mfs_pkg::PID_W-1:0];
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    quantum_r    <= quantum_nxt;
    user_r       <= user_nxt;
    pick_lvl_r   <= pick_lvl_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
  end

  assign res_ext       = 32'(res_id_r);
  assign in_ready      = (state_r == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_picked_id = out_id_r;

  // One request in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in work");

  // No pick means a zero id.
  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != mfs_pkg::ST_PICKED |-> out_picked_id == '0)
    else $error("id shown without a pick");

  // A pop that follows a link leaves its level non-empty.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP |-> nonempty_r[pick_lvl_r])
    else $error("pop from empty level");

  // Sweeps keep the input closed.
  a_sweep_closed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWEEP || state_r == S_CLEAR |-> !in_ready)
    else $error("input open during sweep");

endmodule
